### rtl/core/mrp_pkg.sv
package mrp_pkg;

  localparam int MSG_DEPTH = 64;
  localparam int ADDR_W    = $clog2(MSG_DEPTH);
  localparam int LEN_W     = $clog2(MSG_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_CTL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ID_THIRD  = 3'd4;

  localparam logic [4:0] RST_LISTEN_CH = 5'd0;
  localparam logic [6:0] RST_BANK_CTL  = 7'd0;
  localparam logic [6:0] RST_ID_FIRST  = 7'd0;
  localparam logic [6:0] RST_ID_SECOND = 7'd1;
  localparam logic [6:0] RST_ID_THIRD  = 7'd116;

  // MIDI status codes
  localparam logic [3:0] NIB_CTRL_CHANGE = 4'hB;
  localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
  localparam logic [7:0] SYSEX_START     = 8'hF0;
  localparam logic [7:0] SYSEX_EOX       = 8'hF7;
  localparam logic [4:0] REALTIME_TOP    = 5'b11111;

  // output kinds
  localparam logic KIND_PRESET = 1'b0;
  localparam logic KIND_SYSEX  = 1'b1;

  // a sysex run must be longer than this to be passed on
  localparam int SYSEX_MIN_LEN = 4;

endpackage

### rtl/core/midi_receive_parser_top.sv
// MIDI receive parser.
// Input channel: one received MIDI byte per beat on in_rx_byte (in_valid/in_ready).
// Result channel: out_kind selects a preset change (out_preset_number = bank*128
// + program, out_last high) or one byte of an accepted system exclusive message
// (out_message_byte, out_last high on its end byte).
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 listen channel,
// 1 bank controller, 2..4 manufacturer ID bytes); write only while the block idles.
// Throughput: one byte per cycle while parsing and the output is not stalled. A preset
// is loaded into the output register in the cycle after its program byte is taken.
// At a qualifying sysex end byte the block stops taking input and replays the
// buffered message from its 64-entry byte memory, one beat per cycle while the
// receiver takes them, and holds the input until the end byte is loaded; each byte
// passes from the memory read register to the output register.
// A stalled receiver holds the output register; in_ready then stays low until
// the pending beat is taken.
// Reset (rst_n low, synchronous) returns the parser to idle, clears the bank and
// the output valid flag and loads the register defaults; the memory is not cleared.
module midi_receive_parser_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [15:0]                     out_preset_number,
  output logic [7:0]                      out_message_byte,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [mrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_CTRL  = 3'd1;
  localparam logic [2:0] MODE_VALUE = 3'd2;
  localparam logic [2:0] MODE_PROG  = 3'd3;
  localparam logic [2:0] MODE_SYSEX = 3'd4;
  localparam logic [2:0] MODE_EMIT  = 3'd5;

  localparam int LW = mrp_pkg::LEN_W;
  localparam int AW = mrp_pkg::ADDR_W;

  // configuration
  logic [4:0] listen_ch_r;
  logic [6:0] bank_ctl_r;
  logic [6:0] id_first_r;
  logic [6:0] id_second_r;
  logic [6:0] id_third_r;

  // parser state
  logic [2:0]    mode_r, mode_nxt;
  logic [6:0]    bank_r, bank_nxt;
  logic          ctl_match_r, ctl_match_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    id1_r, id1_nxt;
  logic [7:0]    id2_r, id2_nxt;
  logic [7:0]    id3_r, id3_nxt;

  // replay state
  logic [LW-1:0] emit_len_r, emit_len_nxt;
  logic [LW-1:0] emit_idx_r, emit_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic [7:0]    rd_data_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r;
  logic [15:0]   out_preset_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic [7:0] msg_mem [mrp_pkg::MSG_DEPTH];

  logic          in_acc;
  logic [7:0]    b;
  logic          is_rt;
  logic          ch_ok;
  logic [2:0]    dec_mode;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] len_inc;
  logic          room;
  logic          id_ok;
  logic          preset_ld;
  logic          rd_issue;
  logic          rd_ld;

  assign b        = in_rx_byte;
  assign in_ready = (mode_r != MODE_EMIT) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign is_rt    = (b[7:3] == mrp_pkg::REALTIME_TOP);
  assign ch_ok    = (listen_ch_r == 5'd0) || (listen_ch_r == ({1'b0, b[3:0]} + 5'd1));
  assign len_inc  = len_r + LW'(1);
  assign room     = (len_r < LW'(mrp_pkg::MSG_DEPTH));
  assign id_ok    = (id1_r == {1'b0, id_first_r}) && (id2_r == {1'b0, id_second_r})
                    && (id3_r == {1'b0, id_third_r});

  always_comb begin
    dec_mode = MODE_IDLE;
    if (b[7:4] == mrp_pkg::NIB_CTRL_CHANGE && ch_ok) begin
      dec_mode = MODE_CTRL;
    end else if (b[7:4] == mrp_pkg::NIB_PROG_CHANGE && ch_ok) begin
      dec_mode = MODE_PROG;
    end else if (b == mrp_pkg::SYSEX_START) begin
      dec_mode = MODE_SYSEX;
    end
  end

  // replay handshake: the read register feeds the output register
  assign rd_ld    = rd_pend_r && (!out_valid_r || out_ready);
  assign rd_issue = (mode_r == MODE_EMIT) && (emit_idx_r != emit_len_r)
                    && (!rd_pend_r || rd_ld);

  always_comb begin
    mode_nxt      = mode_r;
    bank_nxt      = bank_r;
    ctl_match_nxt = ctl_match_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    id1_nxt       = id1_r;
    id2_nxt       = id2_r;
    id3_nxt       = id3_r;
    emit_len_nxt  = emit_len_r;
    wr_en         = 1'b0;
    wr_addr       = len_r[AW-1:0];
    preset_ld     = 1'b0;

    if (in_acc && !is_rt) begin
      case (mode_r)
        MODE_CTRL: begin
          if (!b[7]) begin
            ctl_match_nxt = (b[6:0] == bank_ctl_r);
            mode_nxt      = MODE_VALUE;
          end
        end
        MODE_VALUE: begin
          if (!b[7]) begin
            if (ctl_match_r) begin
              bank_nxt = b[6:0];
            end
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_PROG: begin
          if (!b[7]) begin
            preset_ld = 1'b1;
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_SYSEX: begin
          if (b[7] && b != mrp_pkg::SYSEX_EOX) begin
            len_nxt = '0;
          end else begin
            if (room) begin
              wr_en   = 1'b1;
              len_nxt = len_inc;
              if (len_r == LW'(1)) id1_nxt = b;
              if (len_r == LW'(2)) id2_nxt = b;
              if (len_r == LW'(3)) id3_nxt = b;
            end else begin
              ovf_nxt = 1'b1;
            end
            if (b == mrp_pkg::SYSEX_EOX) begin
              mode_nxt = MODE_IDLE;
              // id registers already hold bytes 1..3 once the length reaches four
              if (room && !ovf_r && len_r >= LW'(mrp_pkg::SYSEX_MIN_LEN)
                  && id_ok) begin
                mode_nxt     = MODE_EMIT;
                emit_len_nxt = len_inc;
              end
              len_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end
        default: begin
          if (!b[7]) begin
            mode_nxt = MODE_IDLE;
          end
        end
      endcase

      // fresh status byte: decode it in every waiting mode
      if (b[7] && !(mode_r == MODE_SYSEX && b == mrp_pkg::SYSEX_EOX)) begin
        mode_nxt = dec_mode;
        if (b == mrp_pkg::SYSEX_START) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          len_nxt = LW'(1);
          ovf_nxt = 1'b0;
        end
      end
    end

    if (rd_ld && rd_last_r) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    rd_pend_nxt  = rd_pend_r && !rd_ld;
    rd_last_nxt  = rd_last_r;
    if (mode_r != MODE_EMIT) begin
      emit_idx_nxt = '0;
      rd_pend_nxt  = 1'b0;
    end else if (rd_issue) begin
      emit_idx_nxt = emit_idx_r + LW'(1);
      rd_pend_nxt  = 1'b1;
      rd_last_nxt  = ((emit_idx_r + LW'(1)) == emit_len_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (preset_ld || rd_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_ch_r <= mrp_pkg::RST_LISTEN_CH;
      bank_ctl_r  <= mrp_pkg::RST_BANK_CTL;
      id_first_r  <= mrp_pkg::RST_ID_FIRST;
      id_second_r <= mrp_pkg::RST_ID_SECOND;
      id_third_r  <= mrp_pkg::RST_ID_THIRD;
    end else if (cfg_we) begin
      case (cfg_index)
        mrp_pkg::REG_LISTEN_CH: listen_ch_r <= cfg_wdata[4:0];
        mrp_pkg::REG_BANK_CTL:  bank_ctl_r  <= cfg_wdata;
        mrp_pkg::REG_ID_FIRST:  id_first_r  <= cfg_wdata;
        mrp_pkg::REG_ID_SECOND: id_second_r <= cfg_wdata;
        mrp_pkg::REG_ID_THIRD:  id_third_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      bank_r      <= '0;
      ctl_match_r <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      emit_len_r  <= '0;
      emit_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      bank_r      <= bank_nxt;
      ctl_match_r <= ctl_match_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      emit_len_r  <= emit_len_nxt;
      emit_idx_r  <= emit_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id1_r <= id1_nxt;
    id2_r <= id2_nxt;
    id3_r <= id3_nxt;
  end

  // message memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[wr_addr] <= b;
    end
    if (rd_issue) begin
      rd_data_r <= msg_mem[emit_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (preset_ld) begin
      out_kind_r   <= mrp_pkg::KIND_PRESET;
      out_preset_r <= {2'b00, bank_r, b[6:0]};
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (rd_ld) begin
      out_kind_r   <= mrp_pkg::KIND_SYSEX;
      out_preset_r <= '0;
      out_byte_r   <= rd_data_r;
      out_last_r   <= rd_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_preset_number = out_preset_r;
  assign out_message_byte  = out_byte_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/mrp_checker.sv
module mrp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_kind,
  input logic [15:0]                     out_preset_number,
  input logic [7:0]                      out_message_byte,
  input logic                            out_last
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_preset_number) && $stable(out_message_byte))
    else $error("stalled result beat changed");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_preset_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mrp_pkg::KIND_PRESET |-> out_last
      && out_message_byte == 8'd0 && out_preset_number[15:14] == 2'b00)
    else $error("malformed preset beat");

  a_sysex_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mrp_pkg::KIND_SYSEX |-> out_preset_number == 16'd0)
    else $error("sysex beat carries a preset number");

  // a replay run blocks the input until its end byte is taken
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mrp_pkg::KIND_SYSEX && !out_last |-> !in_ready)
    else $error("input taken during a sysex replay");

endmodule

bind midi_receive_parser_top mrp_checker u_mrp_checker (.*);
